FILE: rtl/core/rmdl_pkg.sv
// Package for the relay minimum-delay lockout block.
// Holds the timing constants, register indexes, state and result types, and a saturating add.
// Depends on nothing; used by rmdl_step and relay_min_delay_lockout.
package rmdl_pkg;

  localparam int TicksPerSecond = 1000;
  localparam int MsW = (TicksPerSecond > 1) ? $clog2(TicksPerSecond) : 1;
  localparam logic [MsW-1:0] MsLast = MsW'(TicksPerSecond - 1);

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgMinDelay = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgInvert = 1'b1;

  localparam int OutDataW = 152;
  localparam int OutUsedW = 148;

  typedef struct packed {
    logic [15:0] min_hold_s;
    logic        invert_output;
  } rmdl_cfg_t;

  typedef struct packed {
    logic           relay_state;
    logic [MsW-1:0] ms_fraction;
    logic [31:0]    secs_since_change;
    logic [31:0]    heat_sum_s;
    logic [31:0]    switch_count;
    logic           error_flag;
  } rmdl_state_t;

  typedef struct packed {
    logic        relay_active;
    logic        pin_level;
    logic        change_refused;
    logic        error_pending;
    logic [15:0] lockout_left_s;
    logic [31:0] cycle_total;
    logic [31:0] heating_done_s;
    logic [31:0] heating_now_s;
    logic [31:0] heating_live_s;
  } rmdl_result_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

FILE: rtl/core/rmdl_step.sv
// Next-state and result logic for one item of the relay lockout controller.
// Purely combinational; uses rmdl_pkg for types, constants and the saturating add.
module rmdl_step (
  input  rmdl_pkg::rmdl_state_t  st_i,
  input  rmdl_pkg::rmdl_cfg_t    cfg_i,
  input  logic                   func_i,
  input  logic                   target_on_i,
  output rmdl_pkg::rmdl_state_t  st_o,
  output rmdl_pkg::rmdl_result_t res_o
);
  import rmdl_pkg::*;

  logic        refused;
  logic        allow;
  logic [31:0] min_ext;
  logic [31:0] now_s;

  assign min_ext = {16'd0, cfg_i.min_hold_s};
  assign allow   = st_i.secs_since_change >= min_ext;

  always_comb begin
    st_o    = st_i;
    refused = 1'b0;
    if (!func_i) begin
      if (st_i.ms_fraction == MsLast) begin
        st_o.ms_fraction = '0;
        if (st_i.secs_since_change != 32'hFFFF_FFFF) begin
          st_o.secs_since_change = st_i.secs_since_change + 32'd1;
        end
      end else begin
        st_o.ms_fraction = st_i.ms_fraction + MsW'(1);
      end
    end else if (target_on_i != st_i.relay_state) begin
      if (!allow) begin
        refused         = 1'b1;
        st_o.error_flag = 1'b1;
      end else begin
        st_o.error_flag = 1'b0;
        if (target_on_i) begin
          st_o.switch_count = st_i.switch_count + 32'd1;
        end else begin
          st_o.heat_sum_s = sat_add32(st_i.heat_sum_s, st_i.secs_since_change);
        end
        st_o.relay_state       = target_on_i;
        st_o.secs_since_change = '0;
        st_o.ms_fraction       = '0;
      end
    end
  end

  assign now_s = st_o.relay_state ? st_o.secs_since_change : 32'd0;

  always_comb begin
    res_o.relay_active   = st_o.relay_state;
    res_o.pin_level      = st_o.relay_state ^ cfg_i.invert_output;
    res_o.change_refused = refused;
    res_o.error_pending  = st_o.error_flag;
    res_o.lockout_left_s = (st_o.secs_since_change < min_ext)
                           ? (cfg_i.min_hold_s - st_o.secs_since_change[15:0]) : 16'd0;
    res_o.cycle_total    = st_o.switch_count;
    res_o.heating_done_s = st_o.heat_sum_s;
    res_o.heating_now_s  = now_s;
    res_o.heating_live_s = sat_add32(st_o.heat_sum_s, now_s);
  end

endmodule

FILE: rtl/core/relay_min_delay_lockout.sv
// Relay controller with anti-short-cycle lockout: one result per input transfer.
// A result is registered and appears on the master side in the cycle after its input transfer.
// Throughput: one transfer per cycle unless the master stalls; output refills as it drains.
// Reset (rst_ni, asynchronous, active low) clears relay state, counters, error flag and config.
// Depends on rmdl_pkg and rmdl_step.
module relay_min_delay_lockout (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rmdl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [15:0]                     cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [0] target_on, [7:1] zero
  input  logic                            s_axis_tuser_i,  // [0] func
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [0] relay_active, [1] pin_level, [2] change_refused, [3] error_pending,
  // [19:4] lockout_left_s, [51:20] cycle_total, [83:52] heating_done_s,
  // [115:84] heating_now_s, [147:116] heating_live_s, [151:148] zero
  output logic [rmdl_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import rmdl_pkg::*;

  rmdl_cfg_t    cfg_q;
  rmdl_state_t  st_q, st_d;
  rmdl_result_t res_d, res_q;
  logic         out_valid_q;
  logic         accept;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  rmdl_step u_step (
    .st_i        (st_q),
    .cfg_i       (cfg_q),
    .func_i      (s_axis_tuser_i),
    .target_on_i (s_axis_tdata_i[0]),
    .st_o        (st_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinDelay: cfg_q.min_hold_s    <= cfg_data_i;
        CfgInvert:   cfg_q.invert_output <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        st_q <= st_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - OutUsedW)'(0),
                            res_q.heating_live_s, res_q.heating_now_s,
                            res_q.heating_done_s, res_q.cycle_total,
                            res_q.lockout_left_s, res_q.error_pending,
                            res_q.change_refused, res_q.pin_level, res_q.relay_active};

`ifndef SYNTH
  a_relay_holds_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(st_q.relay_state))
    else $error("relay state changed without an input transfer");

  a_refusal_sets_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_d.change_refused |=> st_q.error_flag)
    else $error("refused request did not set the error flag");

  a_change_restarts_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (st_d.relay_state != st_q.relay_state) |=>
    st_q.secs_since_change == 32'd0 && st_q.ms_fraction == '0)
    else $error("relay change did not restart the seconds count");

  a_off_no_heating_now: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.relay_active |-> res_q.heating_now_s == 32'd0)
    else $error("heating time reported while relay is off");

  a_live_not_below_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.heating_live_s >= res_q.heating_done_s)
    else $error("live heating total below completed total");
`endif

endmodule
